/* src/dssg_pkg.sv */
// ----------------------------------------------------------------------------
// dssg_pkg
// Shared types and constants of the scatter segment generator: stream field
// layout, operation and register codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package dssg_pkg;

  localparam int unsigned MAX_PAIRS = 16;
  localparam int unsigned MAX_RUN   = 64;
  localparam int unsigned IDX_W     = $clog2(MAX_PAIRS);
  localparam int unsigned PC_W      = $clog2(MAX_PAIRS + 1);
  localparam int unsigned CNT_W     = $clog2(MAX_RUN + 1);

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PACKED_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COUNT  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_CONT  = 2'd2
  } op_e;

  // Slave-side tdata layout
  localparam int unsigned S_TDATA_W = 256;
  localparam int unsigned EI_LSB  = 0;
  localparam int unsigned EO_LSB  = 4;
  localparam int unsigned EPO_LSB = 28;
  localparam int unsigned ES_LSB  = 52;
  localparam int unsigned FPO_LSB = 76;
  localparam int unsigned FL_LSB  = 108;
  localparam int unsigned ML_LSB  = 124;
  localparam int unsigned SB_LSB  = 156;
  localparam int unsigned BB_LSB  = 204;

  // Master-side tdata layout
  localparam int unsigned M_TDATA_W = 128;

  typedef struct packed {
    logic load_pair;
    logic capture;
    logic div_start;
    logic div_mlen;
    logic take_init;
    logic take_total;
    logic mul_en;
    logic mul_walk;
    logic mul_ps;
    logic take_base;
    logic srch_clr;
    logic srch_step;
    logic addr_walk;
    logic fix;
    logic first;
    logic wrap;
    logic len;
    logic walk_addr;
    logic cont_init;
    logic emit;
    logic emit_end;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic srch_stop;
    logic pend_valid;
    logic len_nz;
    logic cnt_full;
    logic out_free;
    logic run_active;
  } sts_t;

endpackage

/* src/dssg_div.sv */
// ----------------------------------------------------------------------------
// dssg_div
// Restoring divider, 32-bit dividend by 24-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module dssg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [23:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quotient_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic [24:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [23:0] dvs_q, dvs_d;
  logic [24:0] trial;

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    trial = {rem_q[23:0], quo_q[31]};
    if (start_i) begin
      cnt_d = 6'd32;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = (cnt_q != 6'd0);
  assign quotient_o = quo_q;

endmodule

/* src/dssg_ctrl.sv */
// ----------------------------------------------------------------------------
// dssg_ctrl
// Sequencer of the segment generator: division, typemap search, first
// segment, then the pair walk with one pending segment held for its flags.
// ----------------------------------------------------------------------------
module dssg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic [1:0]          op_i,
  input  dssg_pkg::sts_t      sts_i,
  output logic                s_ready_o,
  output dssg_pkg::cmd_t      cmd_o
);

  typedef enum logic [18:0] {
    ST_IDLE  = 19'h00001,
    ST_DIV1S = 19'h00002,
    ST_DIV1W = 19'h00004,
    ST_DIV2S = 19'h00008,
    ST_DIV2W = 19'h00010,
    ST_MB    = 19'h00020,
    ST_MX    = 19'h00040,
    ST_SRD   = 19'h00080,
    ST_SCMP  = 19'h00100,
    ST_TRD   = 19'h00200,
    ST_FIX   = 19'h00400,
    ST_FIRST = 19'h00800,
    ST_WRAP  = 19'h01000,
    ST_RD    = 19'h02000,
    ST_LEN   = 19'h04000,
    ST_EMITM = 19'h08000,
    ST_MUL   = 19'h10000,
    ST_ADDR  = 19'h20000,
    ST_EMITE = 19'h40000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    cmd_o.addr_walk = 1'b1;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          case (op_i)
            dssg_pkg::OP_LOAD: cmd_o.load_pair = 1'b1;
            dssg_pkg::OP_START: begin
              cmd_o.capture = 1'b1;
              state_d = ST_DIV1S;
            end
            dssg_pkg::OP_CONT: begin
              if (sts_i.run_active) begin
                cmd_o.cont_init = 1'b1;
                state_d = ST_WRAP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV1S: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV1W;
      end
      ST_DIV1W: begin
        if (!sts_i.div_busy) begin
          cmd_o.take_init = 1'b1;
          state_d = ST_DIV2S;
        end
      end
      ST_DIV2S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_mlen  = 1'b1;
        state_d = ST_DIV2W;
      end
      ST_DIV2W: begin
        if (!sts_i.div_busy) begin
          cmd_o.take_total = 1'b1;
          state_d = ST_MB;
        end
      end
      ST_MB: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_ps = 1'b1;
        state_d = ST_MX;
      end
      ST_MX: begin
        cmd_o.take_base = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.srch_clr  = 1'b1;
        state_d = ST_SRD;
      end
      ST_SRD: begin
        cmd_o.addr_walk = 1'b0;
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        cmd_o.addr_walk = 1'b0;
        cmd_o.srch_step = 1'b1;
        state_d = sts_i.srch_stop ? ST_TRD : ST_SRD;
      end
      ST_TRD: begin
        cmd_o.addr_walk = 1'b0;
        state_d = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d = ST_FIRST;
      end
      ST_FIRST: begin
        cmd_o.first = 1'b1;
        state_d = ST_WRAP;
      end
      ST_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d = ST_RD;
      end
      ST_RD: state_d = ST_LEN;
      ST_LEN: begin
        cmd_o.len = 1'b1;
        if (sts_i.pend_valid) begin
          state_d = (sts_i.len_nz && !sts_i.cnt_full) ? ST_EMITM : ST_EMITE;
        end else begin
          state_d = sts_i.len_nz ? ST_MUL : ST_IDLE;
        end
      end
      ST_EMITM: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_walk = 1'b1;
        state_d = ST_ADDR;
      end
      ST_ADDR: begin
        cmd_o.walk_addr = 1'b1;
        state_d = ST_WRAP;
      end
      ST_EMITE: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_end = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_end |=> s_ready_o)
    else $error("run end did not return to idle");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> sts_i.div_busy)
    else $error("divider did not start");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("emit into occupied output");
`endif

endmodule

/* src/dssg_dp.sv */
// ----------------------------------------------------------------------------
// dssg_dp
// Datapath: configuration, typemap table, divider, shared multiplier,
// walk cursors, pending segment and output register.
// ----------------------------------------------------------------------------
module dssg_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dssg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dssg_pkg::CFG_DW-1:0]        cfg_data_i,
  input  logic [dssg_pkg::S_TDATA_W-1:0]     s_data_i,
  input  dssg_pkg::cmd_t                     cmd_i,
  output dssg_pkg::sts_t                     sts_o,
  input  logic                               m_ready_i,
  output logic                               m_valid_o,
  output logic [dssg_pkg::M_TDATA_W-1:0]     m_data_o,
  output logic                               m_first_o,
  output logic                               m_done_o,
  output logic                               m_last_o
);

  localparam int unsigned PC_W  = dssg_pkg::PC_W;
  localparam int unsigned IDX_W = dssg_pkg::IDX_W;
  localparam int unsigned CNT_W = dssg_pkg::CNT_W;

  logic [23:0] ps_q, ext_q;
  logic [4:0]  pcnt_q;

  logic [23:0] po_mem  [dssg_pkg::MAX_PAIRS];
  logic [23:0] ppo_mem [dssg_pkg::MAX_PAIRS];
  logic [23:0] sz_mem  [dssg_pkg::MAX_PAIRS];
  logic [23:0] ent_po_q, ent_ppo_q, ent_sz_q;
  logic [IDX_W-1:0] rd_addr;

  logic [31:0] fso_q, mlen_q, init_q, it_q, ic_q, base_q;
  logic [15:0] flen_q, bd_q, wlen_q;
  logic [47:0] sb_q, bb_q, off_q;
  logic [55:0] prod_q;
  logic [IDX_W-1:0] idx_q;
  logic [PC_W-1:0]  pc_q;
  logic [CNT_W-1:0] cnt_q;
  logic             active_q;

  logic [47:0] pd_dest_q, pd_src_q;
  logic [15:0] pd_len_q, pd_cop_q;
  logic        pd_first_q, pd_v_q;

  logic [47:0] od_dest_q, od_src_q;
  logic [15:0] od_len_q, od_cop_q;
  logic        od_first_q, od_last_q, od_done_q, od_v_q;

  logic [23:0] ps_eff;
  logic [PC_W-1:0] np_eff;
  logic        div_busy;
  logic [31:0] div_quo;
  logic [31:0] mul_a;
  logic [23:0] mul_b;

  logic [32:0] srch_p;
  logic        srch_eq, srch_gt, srch_last, srch_stop;
  logic [IDX_W-1:0] t_calc;

  logic [47:0] off_d;
  logic [34:0] v35;
  logic [15:0] first_len;
  logic [15:0] rem;
  logic [15:0] walk_len;

  assign ps_eff = (ps_q == 24'd0) ? 24'd1 : ps_q;
  assign np_eff = (pcnt_q == 5'd0) ? PC_W'(1) :
                  (pcnt_q > 5'(dssg_pkg::MAX_PAIRS)) ? PC_W'(dssg_pkg::MAX_PAIRS) :
                  PC_W'(pcnt_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q   <= 24'd1;
      ext_q  <= 24'd1;
      pcnt_q <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dssg_pkg::CFG_PACKED_SIZE: ps_q   <= cfg_data_i;
        dssg_pkg::CFG_EXTENT:      ext_q  <= cfg_data_i;
        dssg_pkg::CFG_PAIR_COUNT:  pcnt_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Typemap table
  assign rd_addr = cmd_i.addr_walk ? pc_q[IDX_W-1:0] : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pair) begin
      po_mem[s_data_i[dssg_pkg::EI_LSB +: IDX_W]]  <= s_data_i[dssg_pkg::EO_LSB +: 24];
      ppo_mem[s_data_i[dssg_pkg::EI_LSB +: IDX_W]] <= s_data_i[dssg_pkg::EPO_LSB +: 24];
      sz_mem[s_data_i[dssg_pkg::EI_LSB +: IDX_W]]  <= s_data_i[dssg_pkg::ES_LSB +: 24];
    end
    ent_po_q  <= po_mem[rd_addr];
    ent_ppo_q <= ppo_mem[rd_addr];
    ent_sz_q  <= sz_mem[rd_addr];
  end

  dssg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_mlen ? mlen_q : fso_q),
    .divisor_i  (ps_eff),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign mul_a = cmd_i.mul_walk ? ic_q : init_q;
  assign mul_b = cmd_i.mul_ps ? ps_eff : ext_q;

  // Search for the pair holding the fragment offset
  assign srch_p    = {1'b0, base_q} + {9'b0, ent_ppo_q};
  assign srch_eq   = (srch_p == {1'b0, fso_q});
  assign srch_gt   = (srch_p > {1'b0, fso_q});
  assign srch_last = ({1'b0, idx_q} == PC_W'(np_eff - PC_W'(1)));
  assign srch_stop = srch_eq || srch_gt || srch_last;
  always_comb begin
    t_calc = idx_q;
    if (!srch_eq && srch_gt) begin
      t_calc = (idx_q == '0) ? '0 : idx_q - IDX_W'(1);
    end
  end

  // First segment length and destination offset
  assign off_d = {16'b0, fso_q} + {24'b0, ent_po_q} - {16'b0, base_q} - {24'b0, ent_ppo_q};
  assign v35   = {11'b0, ent_sz_q} + {3'b0, base_q} + {11'b0, ent_ppo_q} - {3'b0, fso_q};
  always_comb begin
    if (flen_q == 16'd0) begin
      first_len = 16'd0;
    end else if (v35[34] || (v35 > {19'b0, flen_q})) begin
      first_len = flen_q;
    end else begin
      first_len = v35[15:0];
    end
  end

  // Walk segment length
  assign rem = flen_q - bd_q;
  always_comb begin
    if ((bd_q >= flen_q) || (ic_q >= it_q)) begin
      walk_len = 16'd0;
    end else if (ent_sz_q < {8'b0, rem}) begin
      walk_len = ent_sz_q[15:0];
    end else begin
      walk_len = rem;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q     <= '0;
      it_q     <= '0;
      pc_q     <= '0;
      bd_q     <= '0;
      flen_q   <= '0;
      sb_q     <= '0;
      bb_q     <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      active_q <= 1'b0;
      pd_v_q   <= 1'b0;
      od_v_q   <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        flen_q <= s_data_i[dssg_pkg::FL_LSB +: 16];
        sb_q   <= s_data_i[dssg_pkg::SB_LSB +: 48];
        bb_q   <= s_data_i[dssg_pkg::BB_LSB +: 48];
      end
      if (cmd_i.take_total) it_q <= div_quo;
      if (cmd_i.srch_clr) idx_q <= '0;
      if (cmd_i.srch_step) begin
        idx_q <= srch_stop ? t_calc : idx_q + IDX_W'(1);
      end
      if (cmd_i.first) begin
        bd_q   <= wlen_q;
        ic_q   <= init_q;
        pc_q   <= PC_W'({1'b0, idx_q} + PC_W'(1));
        cnt_q  <= CNT_W'(1);
        pd_v_q <= 1'b1;
      end
      if (cmd_i.cont_init) begin
        cnt_q  <= '0;
        pd_v_q <= 1'b0;
      end
      if (cmd_i.wrap && (pc_q >= np_eff)) begin
        pc_q <= '0;
        if (ic_q < it_q) ic_q <= ic_q + 32'd1;
      end
      if (cmd_i.len) active_q <= (walk_len != 16'd0);
      if (cmd_i.walk_addr) begin
        bd_q   <= bd_q + wlen_q;
        pc_q   <= pc_q + PC_W'(1);
        cnt_q  <= cnt_q + CNT_W'(1);
        pd_v_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        pd_v_q <= 1'b0;
        od_v_q <= 1'b1;
      end else if (m_ready_i) begin
        od_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      fso_q  <= s_data_i[dssg_pkg::FPO_LSB +: 32];
      mlen_q <= s_data_i[dssg_pkg::ML_LSB +: 32];
    end
    if (cmd_i.take_init) init_q <= div_quo;
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
    if (cmd_i.take_base) base_q <= prod_q[31:0];
    if (cmd_i.fix) begin
      off_q  <= off_d;
      wlen_q <= first_len;
    end
    if (cmd_i.len) wlen_q <= walk_len;
    if (cmd_i.first) begin
      pd_dest_q  <= bb_q + prod_q[47:0] + off_q;
      pd_src_q   <= sb_q;
      pd_len_q   <= wlen_q;
      pd_cop_q   <= wlen_q;
      pd_first_q <= 1'b1;
    end
    if (cmd_i.walk_addr) begin
      pd_dest_q  <= bb_q + prod_q[47:0] + {24'b0, ent_po_q};
      pd_src_q   <= sb_q + {32'b0, bd_q};
      pd_len_q   <= wlen_q;
      pd_cop_q   <= bd_q + wlen_q;
      pd_first_q <= 1'b0;
    end
    if (cmd_i.emit) begin
      od_dest_q  <= pd_dest_q;
      od_src_q   <= pd_src_q;
      od_len_q   <= pd_len_q;
      od_cop_q   <= pd_cop_q;
      od_first_q <= pd_first_q;
      od_last_q  <= cmd_i.emit_end;
      od_done_q  <= cmd_i.emit_end && !active_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.div_busy   = div_busy;
    sts_o.srch_stop  = srch_stop;
    sts_o.pend_valid = pd_v_q;
    sts_o.len_nz     = (walk_len != 16'd0);
    sts_o.cnt_full   = (cnt_q == CNT_W'(dssg_pkg::MAX_RUN));
    sts_o.out_free   = !od_v_q || m_ready_i;
    sts_o.run_active = active_q;
  end

  assign m_valid_o = od_v_q;
  assign m_data_o  = {od_cop_q, od_len_q, od_src_q, od_dest_q};
  assign m_first_o = od_first_q;
  assign m_done_o  = od_done_q;
  assign m_last_o  = od_last_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(dssg_pkg::MAX_RUN))
    else $error("segment count beyond run limit");
  a_emit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> pd_v_q)
    else $error("emit without pending segment");
  a_bytes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_addr |=> bd_q <= flen_q)
    else $error("scattered bytes exceed fragment length");
`endif

endmodule

/* src/datatype_scatter_segment_generator.sv */
// ----------------------------------------------------------------------------
// datatype_scatter_segment_generator
// Typemap scatter segment generator: turns received fragments into
// (destination, source, length) scatter requests for a derived datatype.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A load request writes one typemap pair. A
// start request runs two restoring divisions (fragment offset and message
// length by the packed size), two multiplications, a table search reading and
// comparing one pair per step, a table read, a fix-up and the first segment;
// then every further segment passes through wrap, table read, length, multiply
// and address, handing the previous segment to the output register before the
// multiply once that register is free. A continue request goes straight to the
// walk if a run is active. At most 64 segments leave per request; the last one
// carries tlast, and fragment_done tells whether a continue is still due. The
// output register lets a finished segment wait for m_axis_tready while the
// block returns to idle and takes the next request.
// ----------------------------------------------------------------------------
module datatype_scatter_segment_generator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration: 0 packed_size, 1 extent, 2 pair_count
  input  logic                                 cfg_we_i,
  input  logic [dssg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dssg_pkg::CFG_DW-1:0]          cfg_data_i,
  // Request stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0: entry_index(4) entry_offset(24) entry_packed_offset(24)
  // entry_size(24) frag_packed_offset(32) frag_length(16) message_length(32)
  // source_base(48) buffer_base(48), zero pad(4)
  input  logic [dssg_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  // tuser: operation(2)
  input  logic [1:0]                           s_axis_tuser,
  // Segment stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata from bit 0: dest_address(48) source_address(48) segment_length(16)
  // copied_total(16)
  output logic [dssg_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // tuser from bit 0: first_segment(1) fragment_done(1)
  output logic [1:0]                           m_axis_tuser,
  // last_of_run
  output logic                                 m_axis_tlast
);

  dssg_pkg::cmd_t cmd;
  dssg_pkg::sts_t sts;
  logic           m_first;
  logic           m_done;

  // Sequencer: decides the order of work, holds the block busy per request
  dssg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .op_i      (s_axis_tuser),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  // Datapath: table, divider, multiplier, cursors and output register
  dssg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_data_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata),
    .m_first_o   (m_first),
    .m_done_o    (m_done),
    .m_last_o    (m_axis_tlast)
  );

  assign m_axis_tuser = {m_done, m_first};

endmodule
